### src/odo_pkg.sv
// Package for the differential drive odometry block.
// Holds shared types, fixed-point constants, the arctangent table and helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package odo_pkg;

	localparam int COUNT_BITS   = 32;
	localparam int CORDIC_STEPS = 16;
	localparam int ATAN_ENTRIES = 24;
	localparam int COR_ITERS    = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
	localparam int K_W          = $clog2(COR_ITERS + 2);

	localparam logic signed [20:0] PI_Q16      = 21'sd205887;
	localparam logic signed [20:0] TWO_PI_Q16  = 21'sd411774;
	localparam logic signed [20:0] HALF_PI_Q16 = 21'sd102944;
	localparam logic [19:0]        TWO_PI_U    = 20'd411774;
	localparam logic signed [34:0] CORDIC_GAIN = 35'sd652032874;

	// floor(2^57 / 2pi in Q16); the quotient it gives is low by at most one
	localparam logic [39:0] TWO_PI_RECIP = 40'((64'd1 << 57) / 64'd411774);

	// multiplier phase: operand load, five digit steps, capture
	localparam logic [K_W-1:0] MUL_LAST = K_W'(6);
	// remainder phase: multiplier steps, remainder capture, heading update
	localparam logic [K_W-1:0] REM_LAST = K_W'(7);
	localparam logic [K_W-1:0] COR_LAST = K_W'(COR_ITERS + 1);

	typedef enum logic [3:0] {
		PH_MR  = 4'd0,
		PH_ML  = 4'd1,
		PH_TH  = 4'd2,
		PH_REM = 4'd3,
		PH_COR = 4'd4,
		PH_X   = 4'd5,
		PH_Y   = 4'd6,
		PH_V   = 4'd7,
		PH_W   = 4'd8
	} ph_t;

	localparam logic [1:0] REG_MM_PER_COUNT = 2'd0;
	localparam logic [1:0] REG_SAMPLE_RATE  = 2'd1;
	localparam logic [1:0] REG_TRACK_RECIP  = 2'd2;
	localparam logic [1:0] REG_INVERT_LEFT  = 2'd3;

	typedef struct packed {
		logic [23:0] mm_per_count;
		logic [15:0] sample_rate_hz;
		logic [31:0] track_width_recip;
		logic        invert_left;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic run;
		ph_t  phase;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic done;
		logic out_busy;
	} sts_t;

	// rounded arctangent of 2^-i in Q2.30
	function automatic logic signed [32:0] atan_q30(input logic [4:0] i);
		logic signed [32:0] r;
		case (i)
			5'd0:  r = 33'sd843314857;
			5'd1:  r = 33'sd497837830;
			5'd2:  r = 33'sd263043837;
			5'd3:  r = 33'sd133525159;
			5'd4:  r = 33'sd67021687;
			5'd5:  r = 33'sd33543516;
			5'd6:  r = 33'sd16775851;
			5'd7:  r = 33'sd8388437;
			5'd8:  r = 33'sd4194283;
			5'd9:  r = 33'sd2097149;
			5'd10: r = 33'sd1048576;
			5'd11: r = 33'sd524288;
			5'd12: r = 33'sd262144;
			5'd13: r = 33'sd131072;
			5'd14: r = 33'sd65536;
			5'd15: r = 33'sd32768;
			5'd16: r = 33'sd16384;
			5'd17: r = 33'sd8192;
			5'd18: r = 33'sd4096;
			5'd19: r = 33'sd2048;
			5'd20: r = 33'sd1024;
			5'd21: r = 33'sd512;
			5'd22: r = 33'sd256;
			5'd23: r = 33'sd128;
			default: r = 33'sd0;
		endcase
		return r;
	endfunction

	// clamp a wide signed value to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [89:0] v);
		logic signed [31:0] r;
		if (v > 90'sd2147483647)
			r = 32'sh7FFFFFFF;
		else if (v < -90'sd2147483648)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage
`default_nettype wire

### src/odo_cfg.sv
// APB-style configuration register file for the odometry block.
// Depends on odo_pkg for the register indexes and the cfg_t type.
`timescale 1ns / 1ps
`default_nettype none
module odo_cfg (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               psel,
	input  wire               penable,
	input  wire               pwrite,
	input  wire  [3:0]        paddr,
	input  wire  [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output odo_pkg::cfg_t     cfg
);

	odo_pkg::cfg_t cfg_q;
	logic          wr;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mm_per_count      <= 24'd271790;
			cfg_q.sample_rate_hz    <= 16'd250;
			cfg_q.track_width_recip <= 32'd15339168;
			cfg_q.invert_left       <= 1'b1;
		end else if (wr) begin
			case (paddr[3:2])
				odo_pkg::REG_MM_PER_COUNT: cfg_q.mm_per_count      <= pwdata[23:0];
				odo_pkg::REG_SAMPLE_RATE:  cfg_q.sample_rate_hz    <= pwdata[15:0];
				odo_pkg::REG_TRACK_RECIP:  cfg_q.track_width_recip <= pwdata;
				odo_pkg::REG_INVERT_LEFT:  cfg_q.invert_left       <= pwdata[0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (paddr[3:2])
			odo_pkg::REG_MM_PER_COUNT: prdata = {8'd0, cfg_q.mm_per_count};
			odo_pkg::REG_SAMPLE_RATE:  prdata = {16'd0, cfg_q.sample_rate_hz};
			odo_pkg::REG_TRACK_RECIP:  prdata = cfg_q.track_width_recip;
			odo_pkg::REG_INVERT_LEFT:  prdata = {31'd0, cfg_q.invert_left};
			default:                   prdata = 32'd0;
		endcase
	end

endmodule
`default_nettype wire

### src/odo_ctrl.sv
// Sequencing state machine for the odometry block.
// Depends on odo_pkg for the command and status structs and phase codes.
`timescale 1ns / 1ps
`default_nettype none
module odo_ctrl (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           in_valid,
	output logic          in_ready,
	output odo_pkg::cmd_t cmd,
	input  odo_pkg::sts_t sts
);

	typedef enum logic [10:0] {
		S_IDLE = 11'b00000000001,
		S_MR   = 11'b00000000010,
		S_ML   = 11'b00000000100,
		S_TH   = 11'b00000001000,
		S_REM  = 11'b00000010000,
		S_COR  = 11'b00000100000,
		S_X    = 11'b00001000000,
		S_Y    = 11'b00010000000,
		S_V    = 11'b00100000000,
		S_W    = 11'b01000000000,
		S_OUT  = 11'b10000000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	assign in_ready = (state_q == S_IDLE);

	// next state and datapath commands
	always_comb begin
		state_d      = state_q;
		cmd.load     = 1'b0;
		cmd.run      = 1'b0;
		cmd.phase    = odo_pkg::PH_MR;
		cmd.out_load = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_MR;
				end
			end
			S_MR: begin
				cmd.run = 1'b1; cmd.phase = odo_pkg::PH_MR;
				if (sts.done) state_d = S_ML;
			end
			S_ML: begin
				cmd.run = 1'b1; cmd.phase = odo_pkg::PH_ML;
				if (sts.done) state_d = S_TH;
			end
			S_TH: begin
				cmd.run = 1'b1; cmd.phase = odo_pkg::PH_TH;
				if (sts.done) state_d = S_REM;
			end
			S_REM: begin
				cmd.run = 1'b1; cmd.phase = odo_pkg::PH_REM;
				if (sts.done) state_d = S_COR;
			end
			S_COR: begin
				cmd.run = 1'b1; cmd.phase = odo_pkg::PH_COR;
				if (sts.done) state_d = S_X;
			end
			S_X: begin
				cmd.run = 1'b1; cmd.phase = odo_pkg::PH_X;
				if (sts.done) state_d = S_Y;
			end
			S_Y: begin
				cmd.run = 1'b1; cmd.phase = odo_pkg::PH_Y;
				if (sts.done) state_d = S_V;
			end
			S_V: begin
				cmd.run = 1'b1; cmd.phase = odo_pkg::PH_V;
				if (sts.done) state_d = S_W;
			end
			S_W: begin
				cmd.run = 1'b1; cmd.phase = odo_pkg::PH_W;
				if (sts.done) state_d = S_OUT;
			end
			S_OUT: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule
`default_nettype wire

### src/odo_datapath.sv
// Datapath of the odometry block: count deltas, a digit-serial multiplier,
// a heading remainder unit, a CORDIC, the pose state and the output register.
// Depends on odo_pkg.
`timescale 1ns / 1ps
`default_nettype none
module odo_datapath (
	input  wire                    clk,
	input  wire                    arst_n,
	input  odo_pkg::cfg_t          cfg,
	input  odo_pkg::cmd_t          cmd,
	output odo_pkg::sts_t          sts,
	input  wire signed [31:0]      right_count,
	input  wire signed [31:0]      left_count,
	output logic                   out_valid,
	input  wire                    out_ready,
	output logic signed [31:0]     x_mm,
	output logic signed [31:0]     y_mm,
	output logic signed [18:0]     heading_rad,
	output logic signed [31:0]     linear_speed,
	output logic signed [31:0]     angular_speed
);

	localparam int CB = odo_pkg::COUNT_BITS;

	logic [CB-1:0]        last_r_q, last_l_q;
	logic signed [CB-1:0] dr_q;
	logic signed [CB:0]   dl_q;
	logic signed [CB-1:0] dr_w, dl_w;

	logic [odo_pkg::K_W-1:0] k_q;
	logic                    done;

	// multiplier
	logic signed [49:0] a_q;
	logic signed [39:0] b_q;
	logic signed [89:0] acc_q;
	logic [2:0]         dig_j;
	logic [39:0]        b_sh;
	logic signed [8:0]  dig;
	logic signed [58:0] part;

	// intermediate results
	logic signed [47:0] mr_q, ml_q, mean_q, ml_w;
	logic signed [49:0] dth_q, dth_w;
	logic signed [41:0] dthc_q;
	logic signed [31:0] x_q, y_q, lin_q, ang_q;
	logic signed [18:0] heading_q;

	// remainder unit
	logic [18:0] r_q;
	logic        neg_q;
	logic [18:0] r_w;
	logic [30:0] quo_w;
	logic [20:0] lo_w;
	logic signed [19:0] rem_w;
	logic signed [20:0] h_w, hw_w;

	// cordic
	logic signed [34:0] cx_q, cy_q, cxs, cys;
	logic signed [32:0] cz_q;
	logic signed [34:0] c_q, s_q;
	logic               flip_q;
	logic [4:0]         ci;
	logic signed [20:0] ang_a;
	logic               ang_flip;

	assign dr_w = signed'(right_count[CB-1:0] - last_r_q);
	assign dl_w = signed'(left_count[CB-1:0] - last_l_q);

	// phase completion
	always_comb begin
		case (cmd.phase)
			odo_pkg::PH_REM: done = (k_q == odo_pkg::REM_LAST);
			odo_pkg::PH_COR: done = (k_q == odo_pkg::COR_LAST);
			default:         done = (k_q == odo_pkg::MUL_LAST);
		endcase
	end
	assign sts.done     = cmd.run && done;
	assign sts.out_busy = out_valid && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)               k_q <= '0;
		else if (!cmd.run || done) k_q <= '0;
		else                       k_q <= k_q + 1'b1;
	end

	// multiplier digit, lowest digit first, top digit signed
	assign dig_j = 3'(k_q - 1'b1);
	assign b_sh  = b_q >> (8 * dig_j);
	assign dig   = (dig_j == 3'd4) ? 9'(signed'(b_sh[7:0])) : signed'({1'b0, b_sh[7:0]});
	assign part  = a_q * dig;

	assign ml_w  = 48'(acc_q >>> 8);
	assign dth_w = 50'(acc_q >>> 32);

	// remainder: quotient from the reciprocal product (bits 57 up), one correction step;
	// only the low bits of the magnitude matter since the remainder is below 2^20
	assign quo_w = acc_q[87:57];
	assign lo_w  = a_q[20:0] - 21'(quo_w * odo_pkg::TWO_PI_U);
	assign r_w   = (lo_w >= 21'(odo_pkg::TWO_PI_U)) ?
	               19'(lo_w - 21'(odo_pkg::TWO_PI_U)) : lo_w[18:0];
	assign rem_w = neg_q ? -20'(signed'({1'b0, r_q})) : 20'(signed'({1'b0, r_q}));
	assign h_w   = 21'(heading_q) + 21'(rem_w);
	always_comb begin
		if (h_w > odo_pkg::PI_Q16)       hw_w = h_w - odo_pkg::TWO_PI_Q16;
		else if (h_w < -odo_pkg::PI_Q16) hw_w = h_w + odo_pkg::TWO_PI_Q16;
		else                             hw_w = h_w;
	end

	// cordic quadrant fold and shifted terms
	always_comb begin
		ang_a    = 21'(heading_q);
		ang_flip = 1'b0;
		if (ang_a > odo_pkg::HALF_PI_Q16) begin
			ang_a = ang_a - odo_pkg::PI_Q16; ang_flip = 1'b1;
		end else if (ang_a < -odo_pkg::HALF_PI_Q16) begin
			ang_a = ang_a + odo_pkg::PI_Q16; ang_flip = 1'b1;
		end
	end
	assign ci  = 5'(k_q - 1'b1);
	assign cxs = cx_q >>> ci;
	assign cys = cy_q >>> ci;

	// count deltas on accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_r_q <= '0;
			last_l_q <= '0;
		end else if (cmd.load) begin
			last_r_q <= right_count[CB-1:0];
			last_l_q <= left_count[CB-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dr_q <= dr_w;
			dl_q <= cfg.invert_left ? -(CB+1)'(dl_w) : (CB+1)'(dl_w);
		end
	end

	// pose state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q       <= '0;
			y_q       <= '0;
			heading_q <= '0;
		end else if (cmd.run && done) begin
			case (cmd.phase)
				odo_pkg::PH_REM: heading_q <= hw_w[18:0];
				odo_pkg::PH_X:   x_q <= odo_pkg::sat32(90'(x_q) + (acc_q >>> 30));
				odo_pkg::PH_Y:   y_q <= odo_pkg::sat32(90'(y_q) + (acc_q >>> 30));
				default: ;
			endcase
		end
	end

	// phase work
	always_ff @(posedge clk) begin
		if (cmd.run) begin
			case (cmd.phase)
				odo_pkg::PH_REM: begin
					if (k_q == '0) begin
						neg_q <= dth_q[49];
						a_q   <= dth_q[49] ? -dth_q : dth_q;
						b_q   <= signed'(odo_pkg::TWO_PI_RECIP);
						acc_q <= '0;
					end else if (k_q < odo_pkg::MUL_LAST) begin
						acc_q <= acc_q + (90'(part) <<< (8 * dig_j));
					end else if (!done) begin
						r_q <= r_w;
					end
				end
				odo_pkg::PH_COR: begin
					if (k_q == '0) begin
						cx_q   <= odo_pkg::CORDIC_GAIN;
						cy_q   <= '0;
						cz_q   <= 33'(ang_a) <<< 14;
						flip_q <= ang_flip;
					end else if (!done) begin
						if (!cz_q[32]) begin
							cx_q <= cx_q - cys;
							cy_q <= cy_q + cxs;
							cz_q <= cz_q - odo_pkg::atan_q30(ci);
						end else begin
							cx_q <= cx_q + cys;
							cy_q <= cy_q - cxs;
							cz_q <= cz_q + odo_pkg::atan_q30(ci);
						end
					end else begin
						c_q <= flip_q ? -cx_q : cx_q;
						s_q <= flip_q ? -cy_q : cy_q;
					end
				end
				default: begin
					if (k_q == '0) begin
						acc_q <= '0;
						case (cmd.phase)
							odo_pkg::PH_MR: begin
								a_q <= 50'(dr_q);
								b_q <= 40'(signed'({1'b0, cfg.mm_per_count}));
							end
							odo_pkg::PH_ML: begin
								a_q <= 50'(dl_q);
								b_q <= 40'(signed'({1'b0, cfg.mm_per_count}));
							end
							odo_pkg::PH_TH: begin
								a_q <= 50'(mr_q) - 50'(ml_q);
								b_q <= 40'(signed'({1'b0, cfg.track_width_recip}));
							end
							odo_pkg::PH_X: begin
								a_q <= 50'(mean_q);
								b_q <= 40'(c_q);
							end
							odo_pkg::PH_Y: begin
								a_q <= 50'(mean_q);
								b_q <= 40'(s_q);
							end
							odo_pkg::PH_V: begin
								a_q <= 50'(mean_q);
								b_q <= 40'(signed'({1'b0, cfg.sample_rate_hz}));
							end
							default: begin
								a_q <= 50'(dthc_q);
								b_q <= 40'(signed'({1'b0, cfg.sample_rate_hz}));
							end
						endcase
					end else if (!done) begin
						acc_q <= acc_q + (90'(part) <<< (8 * dig_j));
					end else begin
						case (cmd.phase)
							odo_pkg::PH_MR: mr_q <= ml_w;
							odo_pkg::PH_ML: begin
								ml_q   <= ml_w;
								mean_q <= 48'((49'(mr_q) + 49'(ml_w)) >>> 1);
							end
							odo_pkg::PH_TH: begin
								dth_q <= dth_w;
								if (dth_w > 50'sd1099511627776)
									dthc_q <= 42'sd1099511627776;
								else if (dth_w < -50'sd1099511627776)
									dthc_q <= -42'sd1099511627776;
								else
									dthc_q <= dth_w[41:0];
							end
							odo_pkg::PH_V: lin_q <= odo_pkg::sat32(acc_q);
							odo_pkg::PH_W: ang_q <= odo_pkg::sat32(acc_q);
							default: ;
						endcase
					end
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)                     out_valid <= 1'b0;
		else if (cmd.out_load)           out_valid <= 1'b1;
		else if (out_valid && out_ready) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			x_mm          <= x_q;
			y_mm          <= y_q;
			heading_rad   <= heading_q;
			linear_speed  <= lin_q;
			angular_speed <= ang_q;
		end
	end

endmodule
`default_nettype wire

### src/differential_drive_odometry.sv
// Top level of the differential drive odometry block.
// Instantiates odo_cfg, odo_ctrl and odo_datapath; depends on odo_pkg.
`timescale 1ns / 1ps
`default_nettype none
// Each input item carries the two accumulated wheel counts and yields one result item with the
// updated pose (x, y, heading) and the linear and angular speed. An item waits for the output
// register until the previous result has been taken. Seven products go through one shared
// multiplier that takes eight bits of its second operand per cycle, the heading step is reduced
// modulo two pi by a reciprocal product on the same multiplier plus one correction step, and
// the CORDIC runs one step per cycle. A new item is accepted once the previous one has been
// handed to the output register, which holds its result until taken. Configuration is written
// through the APB port; the user must do so only while idle, the block does not enforce it.
module differential_drive_odometry (
	input  wire          clk,
	input  wire          arst_n,
	// tdata: right_count[31:0], left_count[63:32]
	input  wire          s_tvalid,
	output logic         s_tready,
	input  wire  [63:0]  s_tdata,
	// tdata: x_mm[31:0], y_mm[63:32], heading_rad[82:64], linear_speed[114:83],
	// angular_speed[146:115], zero fill [151:147]
	output logic         m_tvalid,
	input  wire          m_tready,
	output logic [151:0] m_tdata,
	input  wire          psel,
	input  wire          penable,
	input  wire          pwrite,
	input  wire  [3:0]   paddr,
	input  wire  [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	odo_pkg::cfg_t cfg;
	odo_pkg::cmd_t cmd;
	odo_pkg::sts_t sts;

	logic signed [31:0] x_mm, y_mm, linear_speed, angular_speed;
	logic signed [18:0] heading_rad;

	odo_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	odo_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	odo_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.cmd           (cmd),
		.sts           (sts),
		.right_count   (signed'(s_tdata[31:0])),
		.left_count    (signed'(s_tdata[63:32])),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.x_mm          (x_mm),
		.y_mm          (y_mm),
		.heading_rad   (heading_rad),
		.linear_speed  (linear_speed),
		.angular_speed (angular_speed)
	);

	assign m_tdata = {5'd0, angular_speed, linear_speed, heading_rad, y_mm, x_mm};

endmodule
`default_nettype wire
